### hw/rtl/tsib_pkg.sv
// Shared types, widths and character codes for the timestamp index builder.
package tsib_pkg;

    localparam int DEF_OFFSET_BITS = 48;
    localparam int DEF_STAMP_BITS  = 64;

    localparam int STAMP_FIELD_W  = 64;
    localparam int OFFSET_FIELD_W = 48;
    localparam int NUMBER_W       = 16;
    localparam int BASE_W         = 48;
    localparam int INTERVAL_W     = 32;
    localparam int LIMIT_W        = 16;
    localparam int BYTE_W         = 8;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 48;
    localparam int OUT_DATA_W  = STAMP_FIELD_W + OFFSET_FIELD_W + NUMBER_W;

    localparam logic [CFG_INDEX_W-1:0] REG_BASE_OFFSET    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INDEX_INTERVAL = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_LIMIT    = 2'd2;

    localparam logic [INTERVAL_W-1:0] RST_INTERVAL = 32'd2000;
    localparam logic [LIMIT_W-1:0]    RST_LIMIT    = 16'd20000;

    localparam logic [BYTE_W-1:0] CHAR_HASH    = 8'h23;
    localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;

    typedef struct packed {
        logic [BASE_W-1:0]     base_offset;
        logic [INTERVAL_W-1:0] index_interval;
        logic [LIMIT_W-1:0]    entry_limit;
        logic                  base_load;
    } t_cfg;

    typedef struct packed {
        logic [NUMBER_W-1:0]       entry_number;
        logic [OFFSET_FIELD_W-1:0] term_offset;
        logic [STAMP_FIELD_W-1:0]  entry_timestamp;
    } t_entry;

endpackage

### hw/rtl/tsib_cfg_regs.sv
// Configuration registers of the timestamp index builder.
module tsib_cfg_regs
    import tsib_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                   o_cfg
);

    logic [BASE_W-1:0]     r_base;
    logic [INTERVAL_W-1:0] r_interval;
    logic [LIMIT_W-1:0]    r_limit;
    logic                  w_write;

    assign o_cfg_ready = 1'b1;
    assign w_write     = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= '0;
            r_interval <= RST_INTERVAL;
            r_limit    <= RST_LIMIT;
        end else if (w_write) begin
            unique case (i_cfg_index)
                REG_BASE_OFFSET:    r_base     <= i_cfg_data[BASE_W-1:0];
                REG_INDEX_INTERVAL: r_interval <= i_cfg_data[INTERVAL_W-1:0];
                REG_ENTRY_LIMIT:    r_limit    <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // The byte position is reloaded in the same transfer that writes the base offset.
    always_comb begin
        o_cfg.base_offset    = (w_write && i_cfg_index == REG_BASE_OFFSET)
                               ? i_cfg_data[BASE_W-1:0] : r_base;
        o_cfg.index_interval = r_interval;
        o_cfg.entry_limit    = r_limit;
        o_cfg.base_load      = w_write && i_cfg_index == REG_BASE_OFFSET;
    end

endmodule

### hw/rtl/tsib_parser.sv
// Input register, line parser, timestamp accumulator and index decision.
module tsib_parser
    import tsib_pkg::*;
#(
    parameter int OFFSET_BITS = DEF_OFFSET_BITS,
    parameter int STAMP_BITS  = DEF_STAMP_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_out_free,
    output logic              o_emit,
    output t_entry            o_entry
);

    localparam int EXT_W = 65;

    logic                   r_in_valid;
    logic [BYTE_W-1:0]      r_in_byte;
    logic                   r_in_number, n_in_number;
    logic                   r_skip, n_skip;
    logic [STAMP_BITS-1:0]  r_acc, n_acc;
    logic [STAMP_BITS-1:0]  r_last, n_last;
    logic [OFFSET_BITS-1:0] r_pos;
    logic [NUMBER_W-1:0]    r_made, n_made;

    logic                   w_advance;
    logic                   w_digit;
    logic [STAMP_BITS-1:0]  w_acc10;
    logic [STAMP_BITS:0]    w_thresh;
    logic                   w_gap_ok;
    logic                   w_take;
    logic [EXT_W-1:0]       w_pos_ext;
    logic [EXT_W-1:0]       w_acc_ext;
    logic [EXT_W-1:0]       w_base_ext;

    assign w_advance = r_in_valid && i_out_free;
    assign o_ready   = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte;
        end
    end

    assign w_digit = r_in_byte >= CHAR_ZERO && r_in_byte <= CHAR_NINE;
    // Times ten as two shifted copies; the digit value is the low nibble of its code.
    assign w_acc10 = (r_acc << 3) + (r_acc << 1)
                     + {{(STAMP_BITS-4){1'b0}}, r_in_byte[3:0]};
    // Exact sum, one bit wider, so a large last entry never lets a small stamp through.
    assign w_thresh = {1'b0, r_last} + {{(STAMP_BITS+1-INTERVAL_W){1'b0}}, i_cfg.index_interval};
    assign w_gap_ok = {1'b0, r_acc} > w_thresh;
    assign w_take   = r_in_number && !w_digit && r_made < i_cfg.entry_limit
                      && (r_made == '0 || w_gap_ok);

    always_comb begin
        n_in_number = r_in_number;
        n_skip      = r_skip;
        n_acc       = r_acc;
        n_last      = r_last;
        n_made      = r_made;
        if (r_in_number) begin
            if (w_digit) begin
                n_acc = w_acc10;
            end else begin
                n_in_number = 1'b0;
                if (w_take) begin
                    n_last = r_acc;
                    n_made = r_made + NUMBER_W'(1);
                end
            end
        end else if (r_skip) begin
            if (r_in_byte == CHAR_NEWLINE) begin
                n_skip = 1'b0;
            end
        end else if (r_in_byte == CHAR_HASH) begin
            n_acc       = '0;
            n_in_number = 1'b1;
        end else if (r_in_byte != CHAR_NEWLINE) begin
            n_skip = 1'b1;
        end
    end

    assign w_base_ext = {{(EXT_W-BASE_W){1'b0}}, i_cfg.base_offset};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_number <= 1'b0;
            r_skip      <= 1'b0;
            r_acc       <= '0;
            r_last      <= '0;
            r_made      <= '0;
            r_pos       <= '0;
        end else begin
            if (w_advance) begin
                r_in_number <= n_in_number;
                r_skip      <= n_skip;
                r_acc       <= n_acc;
                r_last      <= n_last;
                r_made      <= n_made;
            end
            if (i_cfg.base_load) begin
                r_pos <= w_base_ext[OFFSET_BITS-1:0];
            end else if (w_advance) begin
                r_pos <= r_pos + OFFSET_BITS'(1);
            end
        end
    end

    assign w_pos_ext = {{(EXT_W-OFFSET_BITS){1'b0}}, r_pos};
    assign w_acc_ext = {{(EXT_W-STAMP_BITS){1'b0}}, r_acc};

    assign o_emit = w_advance && w_take;
    always_comb begin
        o_entry.entry_timestamp = w_acc_ext[STAMP_FIELD_W-1:0];
        o_entry.term_offset     = w_pos_ext[OFFSET_FIELD_W-1:0];
        o_entry.entry_number    = r_made;
    end

    a_modes_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_in_number && r_skip))
        else $error("number and line skip active together");

    a_emit_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |=> r_made == $past(r_made) + 1'b1)
        else $error("entry count did not advance after an entry");

    a_emit_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |=> !r_in_number)
        else $error("timestamp still open after its entry");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !i_out_free |=> r_in_valid && r_in_byte == $past(r_in_byte))
        else $error("held byte lost while the result slot was full");

endmodule

### hw/rtl/tsib_out_reg.sv
// Result register holding one index entry until the downstream transfer.
module tsib_out_reg
    import tsib_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  t_entry                i_entry,
    output logic                  o_free,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [OUT_DATA_W-1:0] o_data
);

    logic   r_valid;
    t_entry r_entry;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_entry;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_entry;

endmodule

### hw/rtl/trace_timestamp_index_builder.sv
// Top level of the timestamp index builder for value-change dump data sections.
//
// Takes the data-section text one byte per transfer and returns an index entry
// (timestamp, file offset of the byte that ended it, entry number) for each
// timestamp line that opens a new index interval, up to the entry limit. A byte
// is held in an input register and parsed; its entry, if any, is loaded into
// and presented from a result register. The block sustains one byte per clock
// while results are taken; the parse stage sets the rate: one multiply-by-ten
// add and one 65-bit compare. When a result waits untaken, the byte behind it
// is held and the input stalls until the result register frees.
module trace_timestamp_index_builder
    import tsib_pkg::*;
#(
    parameter int OFFSET_BITS = DEF_OFFSET_BITS,
    parameter int STAMP_BITS  = DEF_STAMP_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [BYTE_W-1:0]      i_s_tdata,   // [7:0] data_byte
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_DATA_W-1:0]  o_m_tdata,   // [63:0] entry_timestamp,
                                                // [111:64] terminator offset,
                                                // [127:112] entry_number
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg   w_cfg;
    t_entry w_entry;
    logic   w_emit;
    logic   w_out_free;

    tsib_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    tsib_parser #(
        .OFFSET_BITS (OFFSET_BITS),
        .STAMP_BITS  (STAMP_BITS)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_byte     (i_s_tdata),
        .i_out_free (w_out_free),
        .o_emit     (w_emit),
        .o_entry    (w_entry)
    );

    tsib_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_emit),
        .i_entry (w_entry),
        .o_free  (w_out_free),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata)
    );

endmodule
